// ===== hdl/bavr_pkg.sv =====
// Package for the bitmap/attribute raster unit: request codes, queue item kinds,
// register indexes, raster constants and the item structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bavr_pkg;

  // Request codes on the input channel.
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_BORDER = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_FRAME_TICKS = 1'b0;
  localparam logic CFG_LINE_TICKS  = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [16:0] FRAME_TICKS_RST = 17'd69888;
  localparam logic [9:0]  LINE_TICKS_RST  = 10'd224;

  // Raster geometry.
  localparam logic [9:0]  DISP_TICKS   = 10'd128;
  localparam logic [11:0] ROW_FIRST    = 12'd64;
  localparam logic [11:0] ROW_END      = 12'd256;
  localparam logic [12:0] ATT_BASE_RST = 13'h1800;
  localparam logic [3:0]  BORDER_RST   = 4'd15;
  localparam logic [7:0]  BUS_IDLE     = 8'hff;

  // Storage defaults.
  localparam int SCREEN_BYTES_DEF = 8192;
  localparam int MID_DEPTH        = 4;
  localparam int OUT_DEPTH        = 4;

  // What the back end has to do with a queued transaction.
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } item_kind_t;

  // Classified transaction from the front end to the back end.
  typedef struct packed {
    item_kind_t  kind;
    logic        pix_valid;
    logic        fetch;
    logic        irq;
    logic        flash;
    logic [3:0]  border;
    logic [12:0] addr_bmp;
    logic [12:0] addr_att;
    logic [7:0]  wdata;
    logic        rd_disp;
    logic        rd_bitmap;
  } mid_item_t;

  // Finished result waiting on the output channel.
  typedef struct packed {
    logic [31:0] pixel_group;
    logic        pixel_group_valid;
    logic        frame_irq;
    logic [7:0]  bus_data;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/bavr_fifo.sv =====
// Small register-based FIFO used for the front-to-back queue and the result queue.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bavr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         wr_en,
  input  wire logic [WIDTH-1:0]             wr_data,
  input  wire logic                         rd_en,
  output logic      [WIDTH-1:0]             rd_data,
  output logic                              full,
  output logic                              empty,
  output logic      [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = store_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage carries payload only.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      store_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bavr_front.sv =====
// Front end of the raster unit: configuration registers, raster counters and
// classification of each accepted transaction into a queue item. Uses bavr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bavr_front
  import bavr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [1:0]  req_type,
  input  wire logic [12:0] mem_address,
  input  wire logic [7:0]  write_data,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [16:0] cfg_data,
  output mid_item_t        item
);

  logic [16:0] frame_ticks_r, frame_ticks_nxt;
  logic [9:0]  line_ticks_r, line_ticks_nxt;
  logic [16:0] ftc_r, ftc_nxt;
  logic [9:0]  ltc_r, ltc_nxt;
  logic [11:0] ln_r, ln_nxt;
  logic [5:0]  col_r, col_nxt;
  logic [4:0]  flash_r, flash_nxt;
  logic        de_r, de_nxt;
  logic [12:0] bmp_base_r, bmp_base_nxt;
  logic [12:0] att_base_r, att_base_nxt;
  logic [3:0]  border_r, border_nxt;

  logic [16:0] ftc_inc;
  logic [9:0]  ltc_inc;
  logic [11:0] ln_inc;
  logic        disp_row;
  logic [7:0]  trow;
  logic [12:0] bmp_row;
  logic [12:0] att_row;
  logic        group_tick;

  // Saturating and wrapping increments of the raster counters.
  assign ftc_inc    = (ftc_r == '1) ? ftc_r : ftc_r + 1'b1;
  assign ltc_inc    = ltc_r + 1'b1;
  assign ln_inc     = (ln_r == '1) ? ln_r : ln_r + 1'b1;
  assign group_tick = (ftc_r[1:0] == 2'b00);

  // Interleaved row addresses for the line that starts next.
  assign disp_row = (ln_inc >= ROW_FIRST) && (ln_inc < ROW_END);
  assign trow     = ln_inc[7:0] - ROW_FIRST[7:0];
  assign bmp_row  = {trow[7:6], trow[2:0], trow[5:3], 5'b00000};
  assign att_row  = ATT_BASE_RST + {3'b000, trow[7:3], 5'b00000};

  // Next state and queue item for the accepted transaction.
  always_comb begin
    frame_ticks_nxt = frame_ticks_r;
    line_ticks_nxt  = line_ticks_r;
    ftc_nxt         = ftc_r;
    ltc_nxt         = ltc_r;
    ln_nxt          = ln_r;
    col_nxt         = col_r;
    flash_nxt       = flash_r;
    de_nxt          = de_r;
    bmp_base_nxt    = bmp_base_r;
    att_base_nxt    = att_base_r;
    border_nxt      = border_r;
    item            = '0;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_TICKS: frame_ticks_nxt = cfg_data;
        CFG_LINE_TICKS:  line_ticks_nxt  = cfg_data[9:0];
      endcase
    end

    if (accept) begin
      unique case (req_type)
        REQ_TICK: begin
          item.kind      = KIND_TICK;
          item.pix_valid = group_tick;
          item.fetch     = group_tick && de_r;
          item.flash     = flash_r[4];
          item.border    = border_r;
          item.addr_bmp  = bmp_base_r + {7'd0, col_r};
          item.addr_att  = att_base_r + {7'd0, col_r};
          if (group_tick && de_r) begin
            col_nxt = col_r + 1'b1;
          end
          ftc_nxt = ftc_inc;
          ltc_nxt = ltc_inc;
          if (ltc_inc < line_ticks_r) begin
            // Right-hand border starts after the display columns.
            if (ltc_inc >= DISP_TICKS) begin
              de_nxt = 1'b0;
            end
          end else begin
            // Line end: set up the next line.
            col_nxt = '0;
            ln_nxt  = ln_inc;
            ltc_nxt = '0;
            if (disp_row) begin
              de_nxt       = 1'b1;
              bmp_base_nxt = bmp_row;
              att_base_nxt = att_row;
            end else begin
              de_nxt = 1'b0;
            end
            // Frame end is only checked at a line end.
            if (ftc_inc >= frame_ticks_r) begin
              ln_nxt       = '0;
              ftc_nxt      = '0;
              bmp_base_nxt = '0;
              att_base_nxt = ATT_BASE_RST;
              flash_nxt    = flash_r + 1'b1;
              item.irq     = 1'b1;
            end
          end
        end
        REQ_WRITE: begin
          item.kind     = KIND_WRITE;
          item.addr_bmp = mem_address;
          item.wdata    = write_data;
        end
        REQ_BORDER: begin
          border_nxt = write_data[3:0];
        end
        REQ_READ: begin
          item.kind      = KIND_READ;
          item.rd_disp   = de_r;
          item.rd_bitmap = ftc_r[1];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_ticks_r <= FRAME_TICKS_RST;
      line_ticks_r  <= LINE_TICKS_RST;
      ftc_r         <= '0;
      ltc_r         <= '0;
      ln_r          <= '0;
      col_r         <= '0;
      flash_r       <= '0;
      de_r          <= 1'b0;
      bmp_base_r    <= '0;
      att_base_r    <= ATT_BASE_RST;
      border_r      <= BORDER_RST;
    end else begin
      frame_ticks_r <= frame_ticks_nxt;
      line_ticks_r  <= line_ticks_nxt;
      ftc_r         <= ftc_nxt;
      ltc_r         <= ltc_nxt;
      ln_r          <= ln_nxt;
      col_r         <= col_nxt;
      flash_r       <= flash_nxt;
      de_r          <= de_nxt;
      bmp_base_r    <= bmp_base_nxt;
      att_base_r    <= att_base_nxt;
      border_r      <= border_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bavr_back.sv =====
// Back end of the raster unit: screen memory, fetch stage, pixel assembly and the
// result queue. Uses bavr_pkg and bavr_fifo.
`timescale 1ns / 1ps
`default_nettype none

module bavr_back
  import bavr_pkg::*;
#(
  parameter int SCREEN_BYTES = SCREEN_BYTES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  mid_item_t  head,
  input  wire logic  head_valid,
  output logic       head_pop,
  input  wire logic  res_pop,
  output out_item_t  res_item,
  output logic       res_empty
);

  localparam int AW  = $clog2(SCREEN_BYTES);
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  logic [7:0]     mem [SCREEN_BYTES];
  logic [7:0]     bmp_q, att_q;
  mid_item_t      s1_item_r;
  logic           s1_valid_r;
  logic [7:0]     last_bmp_r, last_att_r;
  logic [OCW-1:0] out_count;
  logic [OCW:0]   pending;
  out_item_t      res_nxt;
  logic [3:0]     ink_raw, paper_raw, ink, paper;
  logic           swap;

  // Pop only when the result queue has room for everything in flight.
  assign pending  = {1'b0, out_count} + {{OCW{1'b0}}, s1_valid_r};
  assign head_pop = head_valid && (pending < (OCW + 1)'(OUT_DEPTH));

  // Screen memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (head_pop && (head.kind == KIND_WRITE)) begin
      mem[AW'(head.addr_bmp)] <= head.wdata;
    end
    if (head_pop && head.fetch) begin
      bmp_q <= mem[AW'(head.addr_bmp)];
      att_q <= mem[AW'(head.addr_att)];
    end
  end

  // Fetch stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= head_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      s1_item_r <= head;
    end
  end

  // Bytes seen by the last fetch, returned on bus reads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_bmp_r <= '0;
      last_att_r <= '0;
    end else if (s1_valid_r && s1_item_r.fetch) begin
      last_bmp_r <= bmp_q;
      last_att_r <= att_q;
    end
  end

  // Ink and paper with bright applied, swapped on flashing cells in the flash phase.
  assign ink_raw   = {att_q[6], att_q[2:0]};
  assign paper_raw = {att_q[6], att_q[5:3]};
  assign swap      = att_q[7] && s1_item_r.flash;
  assign ink       = swap ? paper_raw : ink_raw;
  assign paper     = swap ? ink_raw : paper_raw;

  // Result assembly.
  always_comb begin
    res_nxt = '0;
    unique case (s1_item_r.kind)
      KIND_TICK: begin
        res_nxt.pixel_group_valid = s1_item_r.pix_valid;
        res_nxt.frame_irq         = s1_item_r.irq;
        for (int i = 0; i < 8; i++) begin
          if (s1_item_r.fetch) begin
            res_nxt.pixel_group[31 - 4 * i -: 4] = bmp_q[7 - i] ? ink : paper;
          end else if (s1_item_r.pix_valid) begin
            res_nxt.pixel_group[31 - 4 * i -: 4] = s1_item_r.border;
          end
        end
      end
      KIND_READ: begin
        if (s1_item_r.rd_disp) begin
          res_nxt.bus_data = s1_item_r.rd_bitmap ? last_bmp_r : last_att_r;
        end else begin
          res_nxt.bus_data = BUS_IDLE;
        end
      end
      KIND_NONE, KIND_WRITE: begin
        res_nxt = '0;
      end
    endcase
  end

  // The credit check above keeps the result queue from overflowing.
  bavr_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (s1_valid_r),
    .wr_data (res_nxt),
    .rd_en   (res_pop),
    .rd_data (res_item),
    .full    (),
    .empty   (res_empty),
    .count   (out_count)
  );

endmodule

`default_nettype wire

// ===== hdl/bitmap_attribute_video_raster_unit.sv =====
// Top level of the bitmap/attribute raster unit: front end, front-to-back queue and
// back end. Uses bavr_pkg, bavr_front, bavr_fifo and bavr_back.
//
//   Channel   Handshake            Payload
//   input     push / full          in_req_type, in_mem_address, in_write_data
//   result    empty / pop          out_pixel_group, out_pixel_group_valid,
//                                  out_frame_irq, out_bus_data
//   config    cfg_we               cfg_index, cfg_data (no wait, no read-back)
//
// One transaction is accepted per cycle unless full; every one gives exactly one result.
// A result reaches the result side through the front-to-back queue and the fetch stage
// with registered screen memory reads, then the result queue.
// Reset is synchronous and clears all control state; screen memory keeps its contents.
// A stalled result side fills the four-entry result queue, then the four-entry
// front-to-back queue, after which full rises.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_attribute_video_raster_unit
  import bavr_pkg::*;
#(
  parameter int SCREEN_BYTES = SCREEN_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [12:0] in_mem_address,
  input  wire logic [7:0]  in_write_data,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      out_pixel_group,
  output logic             out_pixel_group_valid,
  output logic             out_frame_irq,
  output logic [7:0]       out_bus_data,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [16:0] cfg_data
);

  logic      accept;
  mid_item_t front_item;
  mid_item_t head;
  logic      mid_empty;
  logic      head_pop;
  out_item_t res_item;

  assign accept = push && !full;

  bavr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .req_type    (in_req_type),
    .mem_address (in_mem_address),
    .write_data  (in_write_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .item        (front_item)
  );

  // Queue between classification and execution.
  bavr_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data (front_item),
    .rd_en   (head_pop),
    .rd_data (head),
    .full    (full),
    .empty   (mid_empty),
    .count   ()
  );

  bavr_back #(
    .SCREEN_BYTES (SCREEN_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (!mid_empty),
    .head_pop   (head_pop),
    .res_pop    (pop),
    .res_item   (res_item),
    .res_empty  (empty)
  );

  assign out_pixel_group       = res_item.pixel_group;
  assign out_pixel_group_valid = res_item.pixel_group_valid;
  assign out_frame_irq         = res_item.frame_irq;
  assign out_bus_data          = res_item.bus_data;

endmodule

`default_nettype wire

// ===== hdl/bavr_checker.sv =====
// Port-level checks for the bitmap/attribute raster unit, bound to its top level.
// Depends on bitmap_attribute_video_raster_unit.
`timescale 1ns / 1ps
`default_nettype none

module bavr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [31:0] out_pixel_group,
  input wire logic        out_pixel_group_valid,
  input wire logic        out_frame_irq,
  input wire logic [7:0]  out_bus_data
);

  logic seen_reset_r;

  // Outputs are only meaningful once a reset has been seen.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_reset_r <= 1'b1;
    end
  end

  // Both queues are empty right after reset.
  a_reset_clears: assert property (@(posedge clk)
    (seen_reset_r && !$past(rst_n)) |-> (empty && !full))
    else $error("queues not empty after reset");

  // A result without pixel output carries no pixel bits.
  a_no_stray_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    (seen_reset_r && !empty && !out_pixel_group_valid) |-> (out_pixel_group == 32'd0))
    else $error("pixel bits on a result without a pixel group");

  // Bus data only comes with read results, which never carry pixels or interrupts.
  a_bus_data_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (seen_reset_r && !empty && (out_bus_data != 8'd0)) |->
      (!out_pixel_group_valid && !out_frame_irq))
    else $error("bus data mixed with tick result");

  // A waiting result holds until it is taken.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (seen_reset_r && !empty && !pop) |=>
      (!empty && $stable(out_pixel_group) && $stable(out_bus_data) &&
       $stable(out_frame_irq) && $stable(out_pixel_group_valid)))
    else $error("waiting result changed before it was taken");

endmodule

bind bitmap_attribute_video_raster_unit bavr_checker u_bavr_checker (.*);

`default_nettype wire

// ===== tb/tb_bitmap_attribute_video_raster_unit.sv =====
// Self-checking testbench for bitmap_attribute_video_raster_unit: queued requests are
// driven against a cycle-free model of the raster and every result is compared in order.
// Depends on bavr_pkg and the RTL of the unit; needs no other file.
`timescale 1ns / 1ps

module tb_bitmap_attribute_video_raster_unit;
  import bavr_pkg::*;

  // Safety net far above the slowest legal run.
  localparam int CYCLE_LIMIT = 100_000;

  // One request as it goes onto the input channel.
  typedef struct packed {
    logic [1:0]  req_kind;
    logic [12:0] addr;
    logic [7:0]  data;
  } request_t;

  // Raster state kept by the testbench, one copy live and one for planning.
  typedef struct packed {
    bit [16:0] frame_cnt;
    bit [9:0]  line_cnt;
    bit [11:0] line_no;
    bit [5:0]  col;
    bit [4:0]  flash;
    bit        disp;
    bit [12:0] bmp_base;
    bit [12:0] att_base;
    bit [7:0]  last_bmp;
    bit [7:0]  last_att;
    bit [3:0]  border;
  } raster_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  in_req_type = '0;
  logic [12:0] in_mem_address = '0;
  logic [7:0]  in_write_data = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] out_pixel_group;
  logic        out_pixel_group_valid;
  logic        out_frame_irq;
  logic [7:0]  out_bus_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [16:0] cfg_data = '0;

  // Model state, timing registers and screen contents.
  raster_t    raster;
  raster_t    plan;
  bit [16:0]  frame_len = FRAME_TICKS_RST;
  bit [9:0]   line_len = LINE_TICKS_RST;
  bit [7:0]   screen [SCREEN_BYTES_DEF];
  bit         written [SCREEN_BYTES_DEF];

  request_t   req_backlog[$];
  out_item_t  predicted_out[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int reqs_queued = 0;
  int reqs_taken = 0;
  int results_checked = 0;
  int mismatches = 0;
  int irq_seen = 0;
  int fetch_groups = 0;
  int flash_groups = 0;
  int cycles = 0;

  bitmap_attribute_video_raster_unit dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .push                 (push),
    .full                 (full),
    .in_req_type          (in_req_type),
    .in_mem_address       (in_mem_address),
    .in_write_data        (in_write_data),
    .empty                (empty),
    .pop                  (pop),
    .out_pixel_group      (out_pixel_group),
    .out_pixel_group_valid(out_pixel_group_valid),
    .out_frame_irq        (out_frame_irq),
    .out_bus_data         (out_bus_data),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Advance the raster by one tick and return the pixels it produces.
  function automatic out_item_t advance_raster(inout raster_t s);
    out_item_t  r;
    bit [7:0]   bmp;
    bit [7:0]   att;
    bit [3:0]   ink;
    bit [3:0]   paper;
    bit [3:0]   swap;
    bit [11:0]  trow;
    int         i;
    r = '0;
    if (s.frame_cnt[1:0] == 2'd0) begin
      r.pixel_group_valid = 1'b1;
      if (s.disp) begin
        bmp = screen[s.bmp_base + {7'd0, s.col}];
        att = screen[s.att_base + {7'd0, s.col}];
        s.last_bmp = bmp;
        s.last_att = att;
        ink = {1'b0, att[2:0]};
        paper = {1'b0, att[5:3]};
        if (att[6]) begin
          ink[3] = 1'b1;
          paper[3] = 1'b1;
        end
        // Flash swaps ink and paper during the second half of the flash cycle.
        if (att[7] && s.flash[4]) begin
          swap = ink;
          ink = paper;
          paper = swap;
        end
        s.col = s.col + 6'd1;
        for (i = 0; i < 8; i++) begin
          r.pixel_group = {r.pixel_group[27:0], bmp[7 - i] ? ink : paper};
        end
      end else begin
        r.pixel_group = {8{s.border}};
      end
    end

    if (s.frame_cnt != 17'h1ffff) s.frame_cnt = s.frame_cnt + 17'd1;
    s.line_cnt = s.line_cnt + 10'd1;

    if (s.line_cnt < line_len) begin
      if (s.line_cnt >= DISP_TICKS) s.disp = 1'b0;
    end else begin
      // End of line: step the row and recompute the interleaved row bases.
      s.col = '0;
      if (s.line_no != 12'hfff) s.line_no = s.line_no + 12'd1;
      s.line_cnt = '0;
      if (s.line_no >= ROW_FIRST && s.line_no < ROW_END) begin
        s.disp = 1'b1;
        trow = s.line_no - ROW_FIRST;
        s.bmp_base = {trow[7:6], trow[2:0], trow[5:3], 5'd0};
        s.att_base = ATT_BASE_RST + {3'd0, trow[7:3], 5'd0};
      end else begin
        s.disp = 1'b0;
      end
      if (s.frame_cnt >= frame_len) begin
        s.line_no = '0;
        s.frame_cnt = '0;
        s.bmp_base = '0;
        s.att_base = ATT_BASE_RST;
        s.flash = s.flash + 5'd1;
        r.frame_irq = 1'b1;
      end
    end
    return r;
  endfunction

  // Apply one accepted request to the live model and return its result.
  function automatic out_item_t predict_request(bit [1:0] k, bit [12:0] a, bit [7:0] d);
    out_item_t r;
    r = '0;
    case (k)
      REQ_TICK: begin
        if (raster.disp && raster.frame_cnt[1:0] == 2'd0) begin
          fetch_groups++;
          if (raster.flash[4]) flash_groups++;
        end
        r = advance_raster(raster);
      end
      REQ_WRITE:  screen[a] = d;
      REQ_BORDER: raster.border = d[3:0];
      REQ_READ: begin
        if (raster.disp) r.bus_data = raster.frame_cnt[1] ? raster.last_bmp : raster.last_att;
        else r.bus_data = BUS_IDLE;
      end
    endcase
    return r;
  endfunction

  // Queue one request. A tick that will fetch from screen memory is preceded by
  // writes to any byte it would read that has never been written.
  function automatic void queue_request(bit [1:0] k, bit [12:0] a, bit [7:0] d);
    bit [12:0] bmp_at;
    bit [12:0] att_at;
    request_t  r;
    if (k == REQ_TICK && plan.disp && plan.frame_cnt[1:0] == 2'd0) begin
      bmp_at = plan.bmp_base + {7'd0, plan.col};
      att_at = plan.att_base + {7'd0, plan.col};
      if (!written[bmp_at]) queue_request(REQ_WRITE, bmp_at, 8'($urandom_range(255, 0)));
      if (!written[att_at]) queue_request(REQ_WRITE, att_at, 8'($urandom_range(255, 0)));
    end
    if (k == REQ_WRITE) written[a] = 1'b1;
    r.req_kind = k;
    r.addr = a;
    r.data = d;
    req_backlog.push_back(r);
    reqs_queued++;
    if (k == REQ_TICK) void'(advance_raster(plan));
  endfunction

  // Random request; ticks dominate so that the raster moves along.
  function automatic void queue_random(int tick_pct);
    bit [1:0]  k;
    bit [12:0] a;
    bit [7:0]  d;
    a = 13'($urandom_range(8191, 0));
    d = 8'($urandom_range(255, 0));
    if ($urandom_range(99) < tick_pct) k = REQ_TICK;
    else k = 2'($urandom_range(3, 1));
    // Half the writes are drawn from the bitmap and attribute area only.
    if (k == REQ_WRITE && $urandom_range(1) == 1) a = 13'($urandom_range(13'h1aff, 0));
    queue_request(k, a, d);
  endfunction

  // Program both timing registers; only called while the unit is idle.
  task automatic program_timing(bit [16:0] frame, bit [9:0] line);
    bit [6:0] junk;
    junk = 7'($urandom_range(127, 0));
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_FRAME_TICKS;
    cfg_data <= frame;
    @(posedge clk);
    cfg_index <= CFG_LINE_TICKS;
    cfg_data <= {junk, line};
    @(posedge clk);
    cfg_we <= 1'b0;
    frame_len = frame;
    line_len = line;
    plan = raster;
  endtask

  // Hold until every queued transaction has been taken and answered.
  task automatic drain_results();
    while (reqs_taken != reqs_queued || predicted_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Request driver: takes the next request from the backlog when the sender is not idle.
  always @(posedge clk) begin : drive_requests
    request_t nxt;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predicted_out.push_back(predict_request(in_req_type, in_mem_address, in_write_data));
        reqs_taken++;
      end
      if (!push || !full) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = req_backlog.pop_front();
          push <= 1'b1;
          in_req_type <= nxt.req_kind;
          in_mem_address <= nxt.addr;
          in_write_data <= nxt.data;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each popped transaction with the oldest prediction.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (predicted_out.size() == 0) begin
          $error("result transaction arrived with no request awaiting it");
          mismatches++;
        end else begin
          want = predicted_out.pop_front();
          if (out_pixel_group !== want.pixel_group) begin
            $error("pixel_group: expected %h, got %h", want.pixel_group, out_pixel_group);
            mismatches++;
          end
          if (out_pixel_group_valid !== want.pixel_group_valid) begin
            $error("pixel_group_valid: expected %b, got %b",
                   want.pixel_group_valid, out_pixel_group_valid);
            mismatches++;
          end
          if (out_frame_irq !== want.frame_irq) begin
            $error("frame_irq: expected %b, got %b", want.frame_irq, out_frame_irq);
            mismatches++;
          end
          if (out_bus_data !== want.bus_data) begin
            $error("bus_data: expected %h, got %h", want.bus_data, out_bus_data);
            mismatches++;
          end
          if (want.frame_irq) irq_seen++;
          results_checked++;
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_bitmap_attribute_video_raster_unit: errors");
      $finish;
    end
  end

  initial begin : stimulus
    raster = '0;
    raster.att_base = ATT_BASE_RST;
    raster.border = BORDER_RST;
    plan = raster;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every request type, border nibble, idle bus.
    queue_request(REQ_WRITE, 13'h0000, 8'h00);
    queue_request(REQ_WRITE, 13'h1fff, 8'hff);
    queue_request(REQ_WRITE, 13'h1800, 8'hc7);
    queue_request(REQ_READ, 13'h1fff, 8'hff);
    queue_request(REQ_TICK, 13'h0000, 8'h00);
    queue_request(REQ_BORDER, 13'h0abc, 8'hf0);
    queue_request(REQ_TICK, 13'h1fff, 8'hff);
    queue_request(REQ_READ, 13'h0000, 8'h00);
    queue_request(REQ_TICK, 13'h1555, 8'haa);
    queue_request(REQ_TICK, 13'h0aaa, 8'h55);
    queue_request(REQ_TICK, 13'h0000, 8'h00);
    queue_request(REQ_BORDER, 13'h1fff, 8'h0f);
    queue_request(REQ_TICK, 13'h1fff, 8'hff);
    queue_request(REQ_BORDER, 13'h0000, 8'ha5);
    queue_request(REQ_TICK, 13'h0000, 8'h00);
    queue_request(REQ_TICK, 13'h0000, 8'h00);
    queue_request(REQ_TICK, 13'h0000, 8'h00);
    queue_request(REQ_TICK, 13'h0000, 8'h00);
    queue_request(REQ_READ, 13'h1aff, 8'h3c);
    queue_request(REQ_WRITE, 13'h1aff, 8'h5a);
    drain_results();

    // Shortest regular frame and line: one frame interrupt, sender idling.
    program_timing(17'd256, 10'd128);
    send_idle_pct = 69;
    recv_stall_pct = 0;
    repeat (600) queue_random(70);
    drain_results();

    // Two-tick lines bring the raster to the display rows quickly. The running
    // line count is past the new length, so the first line ends at once.
    program_timing(17'd2000, 10'd2);
    send_idle_pct = 0;
    recv_stall_pct = 69;
    while (plan.line_no < 12'd80) queue_random(92);
    drain_results();

    // Long line inside a display row: fetches across the columns, then the
    // right-hand border once the line passes the display ticks.
    program_timing(17'd2000, 10'd200);
    send_idle_pct = 24;
    recv_stall_pct = 24;
    while (plan.line_cnt < 10'd150) queue_random(92);
    drain_results();

    // Very short frames until the flash phase turns on; the line ends at once.
    program_timing(17'd8, 10'd2);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (!plan.flash[4]) queue_random(85);
    drain_results();

    // Display rows again, now with ink and paper swapped on flashing cells.
    program_timing(17'd2000, 10'd2);
    while (plan.line_no < 12'd76) queue_random(92);
    drain_results();

    // Back to the reset timing with the receiver stalling.
    program_timing(FRAME_TICKS_RST, LINE_TICKS_RST);
    recv_stall_pct = 69;
    repeat (300) queue_random(60);
    drain_results();
    repeat (10) @(posedge clk);

    $display("Covered %0d requests and %0d results: %0d display fetches, %0d in flash phase.",
             reqs_taken, results_checked, fetch_groups, flash_groups);
    $display("Saw %0d frame interrupts over short, display-row and reset-length frames.",
             irq_seen);
    if (mismatches == 0) begin
      $display("tb_bitmap_attribute_video_raster_unit: clean");
    end else begin
      $display("tb_bitmap_attribute_video_raster_unit: errors");
    end
    $finish;
  end

endmodule
